// ----- rtl/playfair_digraph_cipher_core_defines.svh -----
// ----------------------------------------------------------------------------
// Playfair cipher assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_DEFINES_SVH

// same-cycle implication
`define PLF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/plf_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher package
// Widths, letter codes, register indexes and square lookup helpers.
// ----------------------------------------------------------------------------
package plf_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTER_W    = 5;
	localparam int POS_W       = 3;
	localparam int IDX_W       = 5;
	localparam int SQUARE_W    = CELL_COUNT * LETTER_W;
	localparam int CFG_DATA_W  = 50;
	localparam int CFG_IDX_W   = 2;
	localparam int TOP_W       = 25;

	localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
	localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_MID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_TOP = 2'd2;

	typedef logic [SQUARE_W-1:0]   square_t;
	typedef logic [LETTER_W-1:0]   letter_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CELL_COUNT-1:0] match_t;

	typedef struct packed {
		logic  action;
		logic  found_a;
		logic  found_b;
		pos_t  row_a;
		pos_t  col_a;
		pos_t  row_b;
		pos_t  col_b;
	} loc_t;

	function automatic pos_t step_pos(pos_t p, logic back);
		pos_t r;
		if (back) begin
			r = (p == '0) ? pos_t'(SQUARE_SIDE - 1) : p - pos_t'(1);
		end else begin
			r = (p == pos_t'(SQUARE_SIDE - 1)) ? '0 : p + pos_t'(1);
		end
		return r;
	endfunction

	function automatic letter_t cell_rc(square_t sq, pos_t row, pos_t col);
		logic [IDX_W-1:0] idx;
		idx = IDX_W'(int'(row) * SQUARE_SIDE + int'(col));
		return sq[int'(idx) * LETTER_W +: LETTER_W];
	endfunction

endpackage

// ----- rtl/plf_in_if.sv -----
// ----------------------------------------------------------------------------
// Digraph input channel
// Valid/ready channel carrying one digraph and its mode bit per item.
// ----------------------------------------------------------------------------
interface plf_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [plf_pkg::LETTER_W-1:0] first_letter;
	logic [plf_pkg::LETTER_W-1:0] second_letter;

	modport source (output valid, action, first_letter, second_letter, input ready);
	modport sink   (input valid, action, first_letter, second_letter, output ready);
endinterface

// ----- rtl/plf_out_if.sv -----
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one transformed digraph per item.
// ----------------------------------------------------------------------------
interface plf_out_if;
	logic                         valid;
	logic                         ready;
	logic [plf_pkg::LETTER_W-1:0] first_result;
	logic [plf_pkg::LETTER_W-1:0] second_result;
	logic                         letter_missing;

	modport source (output valid, first_result, second_result, letter_missing, input ready);
	modport sink   (input valid, first_result, second_result, letter_missing, output ready);
endinterface

// ----- rtl/plf_locate.sv -----
// ----------------------------------------------------------------------------
// Playfair letter locator
// Stage 1 compares both letters against every cell; stage 2 priority
// encodes the lowest matching cell into row and column.
// ----------------------------------------------------------------------------
module plf_locate (
	input  logic             clk,
	input  logic             arst_n,
	input  plf_pkg::square_t square,
	plf_in_if.sink           digraph,
	output logic             loc_valid,
	input  logic             loc_ready,
	output plf_pkg::loc_t    loc
);
	import plf_pkg::*;

	logic    v_s1;
	logic    act_s1;
	match_t  match_a_s1;
	match_t  match_b_s1;
	logic    v_s2;
	loc_t    loc_s2;

	logic    rdy_s1;
	logic    rdy_s2;
	letter_t let_a;
	letter_t let_b;
	match_t  match_a;
	match_t  match_b;
	loc_t    loc_next;

	assign rdy_s2 = !v_s2 || loc_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign digraph.ready = rdy_s1;

	// J folds onto I
	assign let_a = (digraph.first_letter  == LETTER_J) ? LETTER_I : digraph.first_letter;
	assign let_b = (digraph.second_letter == LETTER_J) ? LETTER_I : digraph.second_letter;

	always_comb begin
		for (int i = 0; i < CELL_COUNT; i++) begin
			match_a[i] = (square[i*LETTER_W +: LETTER_W] == let_a) && (let_a <= LAST_LETTER);
			match_b[i] = (square[i*LETTER_W +: LETTER_W] == let_b) && (let_b <= LAST_LETTER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= digraph.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && digraph.valid) begin
			act_s1     <= digraph.action;
			match_a_s1 <= match_a;
			match_b_s1 <= match_b;
		end
	end

	// lowest cell wins: scan from the top down
	always_comb begin
		loc_next         = '0;
		loc_next.action  = act_s1;
		loc_next.found_a = |match_a_s1;
		loc_next.found_b = |match_b_s1;
		for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
			for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
				if (match_a_s1[r*SQUARE_SIDE + c]) begin
					loc_next.row_a = pos_t'(r);
					loc_next.col_a = pos_t'(c);
				end
				if (match_b_s1[r*SQUARE_SIDE + c]) begin
					loc_next.row_b = pos_t'(r);
					loc_next.col_b = pos_t'(c);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			loc_s2 <= loc_next;
		end
	end

	assign loc_valid = v_s2;
	assign loc       = loc_s2;

endmodule

// ----- rtl/plf_select.sv -----
// ----------------------------------------------------------------------------
// Playfair rule and cell select
// Stage 3 applies the row, column or rectangle rule and reads the new
// letters out of the square into the output register.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_core_defines.svh"

module plf_select (
	input  logic             clk,
	input  logic             arst_n,
	input  plf_pkg::square_t square,
	input  logic             loc_valid,
	output logic             loc_ready,
	input  plf_pkg::loc_t    loc,
	plf_out_if.source        result
);
	import plf_pkg::*;

	logic    v_s3;
	letter_t first_s3;
	letter_t second_s3;
	logic    miss_s3;

	logic    rdy_s3;
	pos_t    row_x;
	pos_t    col_x;
	pos_t    row_y;
	pos_t    col_y;
	letter_t first_next;
	letter_t second_next;
	logic    miss_next;

	assign rdy_s3    = !v_s3 || result.ready;
	assign loc_ready = rdy_s3;

	always_comb begin
		row_x = loc.row_a;
		col_x = loc.col_b;
		row_y = loc.row_b;
		col_y = loc.col_a;
		if (loc.row_a == loc.row_b) begin
			row_x = loc.row_a;
			col_x = step_pos(loc.col_a, loc.action);
			row_y = loc.row_b;
			col_y = step_pos(loc.col_b, loc.action);
		end else if (loc.col_a == loc.col_b) begin
			row_x = step_pos(loc.row_a, loc.action);
			col_x = loc.col_a;
			row_y = step_pos(loc.row_b, loc.action);
			col_y = loc.col_b;
		end
	end

	always_comb begin
		miss_next   = !(loc.found_a && loc.found_b);
		first_next  = miss_next ? '0 : cell_rc(square, row_x, col_x);
		second_next = miss_next ? '0 : cell_rc(square, row_y, col_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= loc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && loc_valid) begin
			first_s3  <= first_next;
			second_s3 <= second_next;
			miss_s3   <= miss_next;
		end
	end

	assign result.valid          = v_s3;
	assign result.first_result   = first_s3;
	assign result.second_result  = second_s3;
	assign result.letter_missing = miss_s3;

	`PLF_ASSERT_NOW(a_miss_zero, v_s3 && miss_s3, first_s3 == '0 && second_s3 == '0, "missing letter with nonzero result")
	`PLF_ASSERT_NEXT(a_load_valid, loc_valid && loc_ready, v_s3, "accepted item lost at output stage")
	`PLF_ASSERT_NEXT(a_miss_flag, loc_valid && loc_ready && !(loc.found_a && loc.found_b), miss_s3, "unfound letter not flagged")

endmodule

// ----- rtl/playfair_digraph_cipher_core.sv -----
// Pipeline: an accepted digraph passes through the match, encode and select stages to its result.
// Throughput: one item per cycle while the output is not stalled; each stage loads when empty or draining.
// The three-stage valid chain stalls from the output back, filling bubbles.
// Reset: arst_n asynchronous, active low; clears stage valids and the key square.
// ----------------------------------------------------------------------------
// Playfair digraph cipher core
// Enciphers or deciphers one digraph per item under a 5x5 key square.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [plf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [plf_pkg::CFG_DATA_W-1:0] wr_data,
	plf_in_if.sink                         digraph,
	plf_out_if.source                      result
);
	import plf_pkg::*;

	square_t square_q;
	logic    loc_valid;
	logic    loc_ready;
	loc_t    loc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CELLS_LOW: square_q[CFG_DATA_W-1:0]              <= wr_data;
				REG_CELLS_MID: square_q[2*CFG_DATA_W-1:CFG_DATA_W]   <= wr_data;
				REG_CELLS_TOP: square_q[SQUARE_W-1:2*CFG_DATA_W]     <= wr_data[TOP_W-1:0];
				default: ;
			endcase
		end
	end

	plf_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.square    (square_q),
		.digraph   (digraph),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready),
		.loc       (loc)
	);

	plf_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.square    (square_q),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready),
		.loc       (loc),
		.result    (result)
	);

endmodule
